>>> rtl/tfbc_pkg.sv
package tfbc_pkg;

	// coordinate format
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// projection divider: one quotient bit per pipeline stage
	localparam int DIV_STEPS = COORD_WIDTH + FRAC_BITS;
	localparam int QUO_WIDTH = DIV_STEPS;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	// back-face merge stages after the projection
	localparam int MERGE_LAT = 3;
	localparam int TOTAL_LAT = DIV_LAT + MERGE_LAT;

	localparam int NUM_VERTS  = 3;
	localparam int NUM_PLANES = 6;

	// plane bit positions in the outside mask
	localparam int PL_LEFT   = 0;
	localparam int PL_RIGHT  = 1;
	localparam int PL_BOTTOM = 2;
	localparam int PL_TOP    = 3;
	localparam int PL_NEAR   = 4;
	localparam int PL_FAR    = 5;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [NUM_PLANES-1:0] mask_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vertex_t;

	typedef struct packed {
		mask_t mask;
		logic  outside;
		logic  back;
		logic  discard;
	} result_t;

endpackage

>>> rtl/tfbc_div.sv
module tfbc_div import tfbc_pkg::*; (
	input  logic   clk,
	input  coord_t num,
	input  coord_t den,
	output coord_t quo
);

	localparam logic [COORD_WIDTH-1:0] HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [COORD_WIDTH-1:0] num_s [0:DIV_STEPS];
	logic [COORD_WIDTH-1:0] den_s [0:DIV_STEPS];
	logic [COORD_WIDTH-2:0] rem_s [0:DIV_STEPS];
	logic [QUO_WIDTH-1:0]   quo_s [0:DIV_STEPS];
	logic                   neg_s [0:DIV_STEPS];
	logic                   zero_s [0:DIV_STEPS];

	logic [COORD_WIDTH-1:0] lim;
	logic [COORD_WIDTH-1:0] mag_q;
	logic                   over;
	coord_t                 res_q;

	// input stage: magnitudes and sign of the quotient
	always_ff @(posedge clk) begin
		num_s[0]  <= num[COORD_WIDTH-1] ? (~num + 1'b1) : num;
		den_s[0]  <= den[COORD_WIDTH-1] ? (~den + 1'b1) : den;
		rem_s[0]  <= '0;
		quo_s[0]  <= '0;
		neg_s[0]  <= num[COORD_WIDTH-1] ^ den[COORD_WIDTH-1];
		zero_s[0] <= (num == '0);
	end

	// restoring division of (num << FRAC_BITS) by den, msb first
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int BIT = DIV_STEPS - 1 - j;
		logic                   nbit;
		logic [COORD_WIDTH-1:0] trial;
		logic [COORD_WIDTH:0]   diff;

		if (BIT >= FRAC_BITS) begin : g_hi
			assign nbit = num_s[j][BIT-FRAC_BITS];
		end else begin : g_lo
			assign nbit = 1'b0;
		end

		assign trial = {rem_s[j], nbit};
		assign diff  = {1'b0, trial} - {1'b0, den_s[j]};

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= diff[COORD_WIDTH] ? trial[COORD_WIDTH-2:0] : diff[COORD_WIDTH-2:0];
			quo_s[j+1]  <= {quo_s[j][QUO_WIDTH-2:0], ~diff[COORD_WIDTH]};
			num_s[j+1]  <= num_s[j];
			den_s[j+1]  <= den_s[j];
			neg_s[j+1]  <= neg_s[j];
			zero_s[j+1] <= zero_s[j];
		end
	end

	// saturate to the signed range and restore the sign
	assign lim   = neg_s[DIV_STEPS] ? HALF : (HALF - 1'b1);
	assign over  = quo_s[DIV_STEPS] > {{(QUO_WIDTH-COORD_WIDTH){1'b0}}, lim};
	assign mag_q = over ? lim : quo_s[DIV_STEPS][COORD_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (zero_s[DIV_STEPS]) begin
			res_q <= '0;
		end else if (neg_s[DIV_STEPS]) begin
			res_q <= coord_t'(~mag_q + 1'b1);
		end else begin
			res_q <= coord_t'(mag_q);
		end
	end

	assign quo = res_q;

endmodule

>>> rtl/tfbc_lane.sv
module tfbc_lane import tfbc_pkg::*; (
	input  logic    clk,
	input  vertex_t vtx,
	output mask_t   mask,
	output coord_t  sx,
	output coord_t  sy
);

	logic signed [COORD_WIDTH:0] xe;
	logic signed [COORD_WIDTH:0] ye;
	logic signed [COORD_WIDTH:0] ze;
	logic signed [COORD_WIDTH:0] we;
	logic signed [COORD_WIDTH:0] nwe;

	// exact plane tests, one bit wider so that -w never overflows
	assign xe  = {vtx.x[COORD_WIDTH-1], vtx.x};
	assign ye  = {vtx.y[COORD_WIDTH-1], vtx.y};
	assign ze  = {vtx.z[COORD_WIDTH-1], vtx.z};
	assign we  = {vtx.w[COORD_WIDTH-1], vtx.w};
	assign nwe = -we;

	always_comb begin
		mask           = '0;
		mask[PL_LEFT]  = xe < nwe;
		mask[PL_RIGHT] = xe > we;
		mask[PL_BOTTOM] = ye < nwe;
		mask[PL_TOP]   = ye > we;
		mask[PL_NEAR]  = vtx.z[COORD_WIDTH-1];
		mask[PL_FAR]   = ze > we;
	end

	// perspective divide of x and y
	tfbc_div u_div_x (
		.clk (clk),
		.num (vtx.x),
		.den (vtx.w),
		.quo (sx)
	);

	tfbc_div u_div_y (
		.clk (clk),
		.num (vtx.y),
		.den (vtx.w),
		.quo (sy)
	);

endmodule

>>> rtl/tfbc_merge.sv
module tfbc_merge import tfbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  mask_t                  mask,
	input  coord_t [NUM_VERTS-1:0] sx,
	input  coord_t [NUM_VERTS-1:0] sy,
	output logic                   done,
	output result_t                res
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [PW-1:0] p_s2, q_s2;
	logic signed [PW:0]   cross_z;
	mask_t                mask_s1, mask_s2;
	logic                 vld_s1, vld_s2, vld_s3;
	result_t              res_s3;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// edge vectors b-a and c-b
	always_ff @(posedge clk) begin
		d1x_s1  <= DW'(sx[1]) - DW'(sx[0]);
		d1y_s1  <= DW'(sy[1]) - DW'(sy[0]);
		d2x_s1  <= DW'(sx[2]) - DW'(sx[1]);
		d2y_s1  <= DW'(sy[2]) - DW'(sy[1]);
		mask_s1 <= mask;
	end

	// cross product terms
	always_ff @(posedge clk) begin
		p_s2    <= PW'(d1x_s1) * PW'(d2y_s1);
		q_s2    <= PW'(d1y_s1) * PW'(d2x_s1);
		mask_s2 <= mask_s1;
	end

	assign cross_z = (PW+1)'(p_s2) - (PW+1)'(q_s2);

	// combine plane rejects and facing
	always_ff @(posedge clk) begin
		res_s3.mask    <= mask_s2;
		res_s3.outside <= |mask_s2;
		res_s3.back    <= ~cross_z[PW];
		res_s3.discard <= (|mask_s2) | ~cross_z[PW];
	end

	assign done = vld_s3;
	assign res  = res_s3;

endmodule

>>> rtl/triangle_frustum_backface_cull_unit.sv
// Triangle trivial reject and back-face cull.
// Input channel: drive the three clip-space vertices (v0..v2, x/y/z/w, signed
// Q16.16) with start high; the triangle is taken at the rising edge where
// start is high and busy is low. busy is always low, so one triangle can be
// presented on every clock.
// Result channel: done is high for exactly one cycle with outside_mask
// (left, right, bottom, top, near, far), outside_volume, back_facing and
// discard valid in that same cycle. Results leave in the order triangles came
// in, one per clock at full rate.
// Path from transfer to done (default format 32-bit Q16.16): the projection
// dividers (one quotient bit per stage, COORD_WIDTH + FRAC_BITS stages plus
// input and saturation registers) followed by three stages for the edge
// vectors, the cross-product multipliers and the final flags.
// The receiver cannot hold results off; results are never stalled.
// Reset clears the valid pipeline, so nothing in flight is reported after
// reset; data registers are not reset.
module triangle_frustum_backface_cull_unit import tfbc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t v0_x,
	input  coord_t v0_y,
	input  coord_t v0_z,
	input  coord_t v0_w,
	input  coord_t v1_x,
	input  coord_t v1_y,
	input  coord_t v1_z,
	input  coord_t v1_w,
	input  coord_t v2_x,
	input  coord_t v2_y,
	input  coord_t v2_z,
	input  coord_t v2_w,
	output logic   done,
	output mask_t  outside_mask,
	output logic   outside_volume,
	output logic   back_facing,
	output logic   discard
);

	vertex_t [NUM_VERTS-1:0] vtx;
	mask_t   [NUM_VERTS-1:0] lane_mask;
	coord_t  [NUM_VERTS-1:0] sx;
	coord_t  [NUM_VERTS-1:0] sy;
	mask_t                   mask_all;
	logic    [DIV_LAT-1:0]   vld_q;
	mask_t                   mask_q [DIV_LAT];
	result_t                 res;
	logic                    xfer;

	assign busy = 1'b0;
	assign xfer = start & ~busy;

	assign vtx[0] = '{x: v0_x, y: v0_y, z: v0_z, w: v0_w};
	assign vtx[1] = '{x: v1_x, y: v1_y, z: v1_z, w: v1_w};
	assign vtx[2] = '{x: v2_x, y: v2_y, z: v2_z, w: v2_w};

	// one lane per vertex
	for (genvar k = 0; k < NUM_VERTS; k++) begin : g_lane
		tfbc_lane u_lane (
			.clk  (clk),
			.vtx  (vtx[k]),
			.mask (lane_mask[k]),
			.sx   (sx[k]),
			.sy   (sy[k])
		);
	end

	// a plane rejects only when every vertex is outside it
	assign mask_all = lane_mask[0] & lane_mask[1] & lane_mask[2];

	// valid and plane mask follow the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DIV_LAT-2:0], xfer};
		end
	end

	always_ff @(posedge clk) begin
		mask_q[0] <= mask_all;
		for (int i = 1; i < DIV_LAT; i++) begin
			mask_q[i] <= mask_q[i-1];
		end
	end

	tfbc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (vld_q[DIV_LAT-1]),
		.mask   (mask_q[DIV_LAT-1]),
		.sx     (sx),
		.sy     (sy),
		.done   (done),
		.res    (res)
	);

	assign outside_mask   = res.mask;
	assign outside_volume = res.outside;
	assign back_facing    = res.back;
	assign discard        = res.discard;

	// every accepted triangle comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> ##TOTAL_LAT done)
		else $error("result missing after accepted triangle");

	// no result without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(xfer, TOTAL_LAT))
		else $error("result strobe without valid pipeline");

	// reject flags agree with the delayed plane mask and the facing flag
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outside_volume == (outside_mask != '0)) &&
			(discard == (outside_volume | back_facing)))
		else $error("reject flags disagree with plane mask");

endmodule

>>> bench/triangle_frustum_backface_cull_unit_tb.sv
module triangle_frustum_backface_cull_unit_tb;
	import tfbc_pkg::*;

	typedef vertex_t [NUM_VERTS-1:0] face_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam int ONE_Q = 1 << FRAC_BITS;
	localparam int RANDOM_FACES = 830;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t v0_x = '0, v0_y = '0, v0_z = '0, v0_w = '0;
	coord_t v1_x = '0, v1_y = '0, v1_z = '0, v1_w = '0;
	coord_t v2_x = '0, v2_y = '0, v2_z = '0, v2_w = '0;
	logic done;
	mask_t outside_mask;
	logic outside_volume;
	logic back_facing;
	logic discard;

	face_t face_pending_q[$];
	result_t cull_expect_q[$];
	face_t cur_face;
	int gap_left = 0;
	int calm_left = 0;
	int err_count = 0;
	int cycle_count = 0;

	triangle_frustum_backface_cull_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z), .v0_w(v0_w),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z), .v1_w(v1_w),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z), .v2_w(v2_w),
		.done(done),
		.outside_mask(outside_mask),
		.outside_volume(outside_volume),
		.back_facing(back_facing),
		.discard(discard)
	);

	always #1 clk = ~clk;

	// perspective divide: truncate toward zero, saturate on overflow or on zero w with a nonzero numerator
	function automatic coord_t project_coord(coord_t num, coord_t den);
		longint sn, sd;
		logic [63:0] n, d, q, lim;
		logic neg;
		sn = num;
		sd = den;
		if (sd == 0) begin
			if (sn > 0)
				return COORD_MAX;
			if (sn < 0)
				return COORD_MIN;
			return '0;
		end
		neg = (sn < 0) != (sd < 0);
		n = (sn < 0) ? -sn : sn;
		d = (sd < 0) ? -sd : sd;
		lim = neg ? (64'd1 << (COORD_WIDTH-1)) : (64'd1 << (COORD_WIDTH-1)) - 64'd1;
		q = (n << FRAC_BITS) / d;
		if (q > lim)
			q = lim;
		if (neg)
			q = -q;
		return q[COORD_WIDTH-1:0];
	endfunction

	// plane reject mask and screen-space winding of one triangle
	function automatic result_t predict_cull(face_t f);
		result_t r;
		mask_t all_out, m;
		longint px[NUM_VERTS], py[NUM_VERTS];
		longint xv, yv, zv, wv;
		logic signed [79:0] ex1, ey1, ex2, ey2, cz;
		all_out = '1;
		for (int k = 0; k < NUM_VERTS; k++) begin
			xv = f[k].x;
			yv = f[k].y;
			zv = f[k].z;
			wv = f[k].w;
			m = '0;
			m[PL_LEFT]   = xv < -wv;
			m[PL_RIGHT]  = xv > wv;
			m[PL_BOTTOM] = yv < -wv;
			m[PL_TOP]    = yv > wv;
			m[PL_NEAR]   = zv < 0;
			m[PL_FAR]    = zv > wv;
			all_out &= m;
			px[k] = project_coord(f[k].x, f[k].w);
			py[k] = project_coord(f[k].y, f[k].w);
		end
		ex1 = px[1] - px[0];
		ey1 = py[1] - py[0];
		ex2 = px[2] - px[1];
		ey2 = py[2] - py[1];
		cz = ex1 * ey2 - ey1 * ex2;
		r.mask = all_out;
		r.outside = |all_out;
		r.back = ~cz[79];
		r.discard = r.outside | r.back;
		return r;
	endfunction

	function automatic vertex_t vtx(int x, int y, int z, int w);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.w = w;
		return v;
	endfunction

	function automatic void add_face(vertex_t a, vertex_t b, vertex_t c);
		face_t f;
		f[0] = a;
		f[1] = b;
		f[2] = c;
		face_pending_q.push_back(f);
	endfunction

	function automatic coord_t pick_corner_coord();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 1;
			2: return -1;
			3: return COORD_MAX;
			4: return COORD_MIN;
			default: return $urandom;
		endcase
	endfunction

	function automatic int spread(int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	// random triangle: raw noise, corner values, or a clip-space sized triangle
	function automatic face_t make_face();
		face_t f;
		int kind, plane, w, r;
		kind = $urandom_range(0, 99);
		plane = (kind >= 25 && $urandom_range(0, 99) < 35) ? $urandom_range(0, 5) : -1;
		for (int k = 0; k < NUM_VERTS; k++) begin
			if (kind < 15) begin
				f[k] = {$urandom, $urandom, $urandom, $urandom};
			end else if (kind < 25) begin
				f[k] = {pick_corner_coord(), pick_corner_coord(),
					pick_corner_coord(), pick_corner_coord()};
			end else begin
				w = $urandom_range(ONE_Q / 4, 4 * ONE_Q);
				if (plane < 0 && $urandom_range(0, 9) == 0)
					w = -w;
				else if (plane < 0 && $urandom_range(0, 19) == 0)
					w = 0;
				f[k].w = w;
				w = (w < 0) ? -w : w;
				f[k].x = spread(2 * w + 1);
				f[k].y = spread(2 * w + 1);
				f[k].z = spread(2 * w + 1);
				r = $urandom_range(0, w);
				case (plane)
					PL_LEFT:   f[k].x = -w - 1 - r;
					PL_RIGHT:  f[k].x = w + 1 + r;
					PL_BOTTOM: f[k].y = -w - 1 - r;
					PL_TOP:    f[k].y = w + 1 + r;
					PL_NEAR:   f[k].z = -1 - r;
					PL_FAR:    f[k].z = w + 1 + r;
					default: ;
				endcase
			end
		end
		// occasional degenerate triangle with a repeated vertex
		if (kind >= 25 && $urandom_range(0, 9) == 0)
			f[2] = f[$urandom_range(0, 1)];
		return f;
	endfunction

	// driver: present queued triangles, back to back or with random idle gaps between transfers
	always @(posedge clk) begin : drive_blk
		logic next_start;
		face_t nf;
		if (arst_n) begin
			next_start = start;
			if (start && !busy) begin
				cull_expect_q.push_back(predict_cull(cur_face));
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (face_pending_q.size() != 0) begin
					nf = face_pending_q.pop_front();
					cur_face = nf;
					v0_x <= nf[0].x; v0_y <= nf[0].y; v0_z <= nf[0].z; v0_w <= nf[0].w;
					v1_x <= nf[1].x; v1_y <= nf[1].y; v1_z <= nf[1].z; v1_w <= nf[1].w;
					v2_x <= nf[2].x; v2_y <= nf[2].y; v2_z <= nf[2].z; v2_w <= nf[2].w;
					next_start = 1'b1;
					if (calm_left != 0) begin
						calm_left--;
						gap_left = 0;
					end else begin
						gap_left = $urandom_range(0, 8);
						if ($urandom_range(0, 15) == 0)
							calm_left = $urandom_range(10, 50);
					end
				end
			end
			start <= next_start;
		end
	end

	// monitor: compare each result transfer against the oldest prediction
	always @(posedge clk) begin : check_blk
		result_t want;
		if (arst_n && done) begin
			if (cull_expect_q.size() == 0) begin
				$display("%0t: unexpected result mask %0h outside %0b back %0b discard %0b",
					$time, outside_mask, outside_volume, back_facing, discard);
				err_count++;
			end else begin
				want = cull_expect_q.pop_front();
				if (outside_mask !== want.mask) begin
					$display("%0t: outside_mask expected %0h got %0h",
						$time, want.mask, outside_mask);
					err_count++;
				end
				if (outside_volume !== want.outside) begin
					$display("%0t: outside_volume expected %0b got %0b",
						$time, want.outside, outside_volume);
					err_count++;
				end
				if (back_facing !== want.back) begin
					$display("%0t: back_facing expected %0b got %0b",
						$time, want.back, back_facing);
					err_count++;
				end
				if (discard !== want.discard) begin
					$display("%0t: discard expected %0b got %0b",
						$time, want.discard, discard);
					err_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// corner fields and degenerate input
		add_face(vtx(0, 0, 0, 0), vtx(0, 0, 0, 0), vtx(0, 0, 0, 0));
		add_face(vtx(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
			vtx(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
			vtx(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		add_face(vtx(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
			vtx(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
			vtx(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		// visible triangle in both windings
		add_face(vtx(0, 0, ONE_Q / 2, ONE_Q), vtx(ONE_Q / 2, 0, ONE_Q / 2, ONE_Q),
			vtx(0, ONE_Q / 2, ONE_Q / 2, ONE_Q));
		add_face(vtx(0, 0, ONE_Q / 2, ONE_Q), vtx(0, ONE_Q / 2, ONE_Q / 2, ONE_Q),
			vtx(ONE_Q / 2, 0, ONE_Q / 2, ONE_Q));
		// each plane rejecting alone
		add_face(vtx(-2 * ONE_Q, 0, ONE_Q / 2, ONE_Q), vtx(-3 * ONE_Q, 0, ONE_Q / 2, ONE_Q),
			vtx(-2 * ONE_Q, ONE_Q / 2, ONE_Q / 2, ONE_Q));
		add_face(vtx(2 * ONE_Q, 0, ONE_Q / 2, ONE_Q), vtx(2 * ONE_Q, ONE_Q / 2, ONE_Q / 2, ONE_Q),
			vtx(3 * ONE_Q, 0, ONE_Q / 2, ONE_Q));
		add_face(vtx(0, -2 * ONE_Q, ONE_Q / 2, ONE_Q), vtx(ONE_Q / 2, -2 * ONE_Q, ONE_Q / 2, ONE_Q),
			vtx(0, -3 * ONE_Q, ONE_Q / 2, ONE_Q));
		add_face(vtx(0, 2 * ONE_Q, ONE_Q / 2, ONE_Q), vtx(0, 3 * ONE_Q, ONE_Q / 2, ONE_Q),
			vtx(ONE_Q / 2, 2 * ONE_Q, ONE_Q / 2, ONE_Q));
		add_face(vtx(0, 0, -ONE_Q, ONE_Q), vtx(ONE_Q / 2, 0, -1, ONE_Q),
			vtx(0, ONE_Q / 2, COORD_MIN, ONE_Q));
		add_face(vtx(0, 0, 2 * ONE_Q, ONE_Q), vtx(0, ONE_Q / 2, ONE_Q + 1, ONE_Q),
			vtx(ONE_Q / 2, 0, COORD_MAX, ONE_Q));
		// vertices exactly on the planes are inside
		add_face(vtx(ONE_Q, ONE_Q, ONE_Q, ONE_Q), vtx(-ONE_Q, -ONE_Q, 0, ONE_Q),
			vtx(ONE_Q, -ONE_Q, ONE_Q, ONE_Q));
		add_face(vtx(-ONE_Q, ONE_Q, 0, ONE_Q), vtx(-ONE_Q, -ONE_Q, 0, ONE_Q),
			vtx(-ONE_Q, 0, 0, ONE_Q));
		// only two of three vertices outside
		add_face(vtx(-2 * ONE_Q, 0, ONE_Q / 2, ONE_Q), vtx(-3 * ONE_Q, ONE_Q / 2, ONE_Q / 2, ONE_Q),
			vtx(0, 0, ONE_Q / 2, ONE_Q));
		// zero w with positive, negative and zero numerators
		add_face(vtx(ONE_Q, -ONE_Q, 0, 0), vtx(0, 0, 0, 0), vtx(-ONE_Q, ONE_Q, 0, 0));
		add_face(vtx(ONE_Q, ONE_Q, ONE_Q, 0), vtx(0, ONE_Q / 2, ONE_Q / 2, ONE_Q),
			vtx(-ONE_Q, 0, 0, ONE_Q));
		// negative w
		add_face(vtx(0, 0, ONE_Q, -ONE_Q), vtx(ONE_Q / 2, 0, 0, -ONE_Q),
			vtx(0, -ONE_Q / 2, ONE_Q, -2 * ONE_Q));
		// quotient overflow in both directions
		add_face(vtx(COORD_MAX, COORD_MIN, 0, 1), vtx(COORD_MIN, COORD_MAX, 0, 1),
			vtx(COORD_MIN, COORD_MIN, 0, -1));
		add_face(vtx(2 * ONE_Q, ONE_Q, 0, 1), vtx(ONE_Q, -ONE_Q, 0, -1),
			vtx(COORD_MAX, 0, 0, COORD_MAX));
		// most negative w
		add_face(vtx(COORD_MIN, 0, 0, COORD_MIN), vtx(COORD_MIN, 1, 0, COORD_MIN),
			vtx(COORD_MIN, -1, 0, COORD_MIN));
		// collinear vertices
		add_face(vtx(0, 0, 0, ONE_Q), vtx(ONE_Q / 4, ONE_Q / 4, 0, ONE_Q),
			vtx(ONE_Q / 2, ONE_Q / 2, 0, ONE_Q));
		// several planes at once, and every plane at once
		add_face(vtx(-2 * ONE_Q, -2 * ONE_Q, 2 * ONE_Q, ONE_Q),
			vtx(-3 * ONE_Q, -2 * ONE_Q, 3 * ONE_Q, ONE_Q),
			vtx(-2 * ONE_Q, -3 * ONE_Q, 2 * ONE_Q, ONE_Q));
		add_face(vtx(0, 0, -1, -2), vtx(0, 0, -1, -2), vtx(0, 0, -1, -2));

		for (int i = 0; i < RANDOM_FACES; i++)
			face_pending_q.push_back(make_face());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (face_pending_q.size() != 0 || start)
			@(posedge clk);
		while (cull_expect_q.size() != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 8) @(posedge clk);

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> triangle_frustum_backface_cull_unit.f
rtl/tfbc_pkg.sv
rtl/tfbc_div.sv
rtl/tfbc_lane.sv
rtl/tfbc_merge.sv
rtl/triangle_frustum_backface_cull_unit.sv
bench/triangle_frustum_backface_cull_unit_tb.sv
